// ===== rtl/smt_pkg.sv =====
// Shared types and constants for the sorted mass table unit.
// Holds the sequencer state enum, command codes and status codes.
// No dependencies.
package smt_pkg;

  localparam int unsigned KeyW    = 64;
  localparam int unsigned MassW   = 32;
  localparam int unsigned DeltaW  = 33;
  localparam int unsigned CountW  = 9;
  localparam int unsigned StatusW = 2;
  localparam int unsigned InDataW  = 200;
  localparam int unsigned OutDataW = 272;
  localparam int unsigned InUserW  = 2;

  localparam logic CMD_APPLY = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [StatusW-1:0] STATUS_OK     = 2'd0;
  localparam logic [StatusW-1:0] STATUS_FULL   = 2'd1;
  localparam logic [StatusW-1:0] STATUS_ABSENT = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH,
    ST_CMP,
    ST_PROBE,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_INS_RD,
    ST_INS_WR,
    ST_NEXT,
    ST_QL,
    ST_QR,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/sorted_mass_table_unit.sv =====
// Sorted mass table unit: sorted key and mass storage with apply and neighbor commands.
// Depends on smt_pkg for the state enum, command codes and status codes.
//
// Channel   Signals                      Item contents
// s_axis    tvalid/tready/tdata/tuser    tdata: position_a, delta_a, position_b, delta_b
//                                        tuser: cmd, two_changes
// m_axis    tvalid/tready/tdata/tuser    tdata: applied_delta_a/b, neighbors, entry_count
//                                        tuser: status
//
// Each key lookup is a binary search over the table memory: each halving step is a read
// and a compare through the single registered memory read port, and a probe read ends it.
// An insert or a removal shifts the entries above the key by one, each entry read and then
// written. An item is accepted in the idle state, and an apply item passes a closing state
// for each change. A neighbor query adds reads of the left and right neighbors, and every
// item ends by loading the output register. One item is in work at a time; a finished
// result waits in the output register while the next item is taken. Reset clears the
// entry count, the sequencer and the output valid; the memory needs no clearing pass.
module sorted_mass_table_unit #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // position_a[63:0], delta_a[96:64], position_b[160:97], delta_b[193:161], zeros above
  input  logic [smt_pkg::InDataW-1:0]      s_axis_tdata,
  // cmd[0], two_changes[1]
  input  logic [smt_pkg::InUserW-1:0]      s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // applied_delta_a[32:0], applied_delta_b[65:33], left_position[129:66],
  // left_mass[161:130], right_position[225:162], right_mass[257:226],
  // entry_count[266:258], zeros above
  output logic [smt_pkg::OutDataW-1:0]     m_axis_tdata,
  // status[1:0]
  output logic [smt_pkg::StatusW-1:0]      m_axis_tuser
);
  import smt_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW = KeyW + MassW;

  state_e state_q, state_d;

  logic [EW-1:0]     mem [TABLE_DEPTH];
  logic [EW-1:0]     rd_q;
  logic [AW-1:0]     rd_addr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [EW-1:0]     mem_wdata;

  logic [CW-1:0]     count_q;
  logic              out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic [StatusW-1:0]  out_user_q;

  logic              cmd_q, two_q, cur_b_q, dropped_q;
  logic [KeyW-1:0]   pos_a_q, pos_b_q;
  logic [DeltaW-1:0] da_q, db_q;
  logic [CW-1:0]     lo_q, hi_q, j_q;
  logic [DeltaW-1:0] app_a_q, app_b_q;
  logic [KeyW-1:0]   lp_q, rp_q;
  logic [MassW-1:0]  lm_q, rm_q;
  logic [StatusW-1:0] status_q;

  logic [CW-1:0]     mid;
  logic [KeyW-1:0]   cur_key;
  logic [DeltaW-1:0] cur_delta;
  logic [KeyW-1:0]   rd_key;
  logic [MassW-1:0]  rd_mass;
  logic [DeltaW:0]   sum;
  logic              sum_le0, sum_sat, present, delta_pos, full, in_acc, out_load;
  logic [DeltaW-1:0] app_val;
  logic [MassW-1:0]  new_mass;

  assign mid       = CW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
  assign cur_key   = cur_b_q ? pos_b_q : pos_a_q;
  assign cur_delta = cur_b_q ? db_q : da_q;
  assign rd_key    = rd_q[EW-1:MassW];
  assign rd_mass   = rd_q[MassW-1:0];
  assign sum       = {2'b00, rd_mass} + {cur_delta[DeltaW-1], cur_delta};
  assign sum_le0   = sum[DeltaW] || (sum == '0);
  assign sum_sat   = !sum[DeltaW] && sum[MassW];
  assign new_mass  = sum_sat ? {MassW{1'b1}} : sum[MassW-1:0];
  assign present   = (lo_q < count_q) && (rd_key == cur_key);
  assign delta_pos = !cur_delta[DeltaW-1] && (cur_delta != '0);
  assign full      = (count_q == CW'(TABLE_DEPTH));
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_load  = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  always_comb begin
    if (present) begin
      if (sum_le0) begin
        app_val = (~{1'b0, rd_mass}) + DeltaW'(1);
      end else begin
        app_val = cur_delta;
      end
    end else if (delta_pos && !full) begin
      app_val = cur_delta;
    end else begin
      app_val = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_SRCH;
      end
      ST_SRCH: begin
        state_d = (lo_q < hi_q) ? ST_CMP : ST_PROBE;
      end
      ST_CMP: state_d = ST_SRCH;
      ST_PROBE: begin
        if (cmd_q == CMD_QUERY) begin
          state_d = present ? ST_QL : ST_DONE;
        end else if (present) begin
          state_d = sum_le0 ? ST_DEL_RD : ST_NEXT;
        end else begin
          state_d = (delta_pos && !full) ? ST_INS_RD : ST_NEXT;
        end
      end
      ST_DEL_RD: state_d = (j_q < count_q) ? ST_DEL_WR : ST_NEXT;
      ST_DEL_WR: state_d = ST_DEL_RD;
      ST_INS_RD: state_d = (j_q > lo_q) ? ST_INS_WR : ST_NEXT;
      ST_INS_WR: state_d = ST_INS_RD;
      ST_NEXT: begin
        state_d = (!cur_b_q && two_q) ? ST_SRCH : ST_DONE;
      end
      ST_QL: state_d = ST_QR;
      ST_QR: state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_addr   = lo_q[AW-1:0];
    mem_we    = 1'b0;
    mem_waddr = lo_q[AW-1:0];
    mem_wdata = rd_q;
    case (state_q)
      ST_SRCH: begin
        rd_addr = (lo_q < hi_q) ? mid[AW-1:0] : lo_q[AW-1:0];
      end
      ST_PROBE: begin
        rd_addr = (lo_q == '0) ? lo_q[AW-1:0] : AW'(lo_q - 1'b1);
        if (cmd_q == CMD_APPLY && present && !sum_le0) begin
          mem_we    = 1'b1;
          mem_wdata = {rd_key, new_mass};
        end
      end
      ST_QL: begin
        rd_addr = ((lo_q + 1'b1) < count_q) ? AW'(lo_q + 1'b1) : lo_q[AW-1:0];
      end
      ST_DEL_RD: rd_addr = j_q[AW-1:0];
      ST_DEL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(j_q - 1'b1);
      end
      ST_INS_RD: begin
        rd_addr = AW'(j_q - 1'b1);
        if (j_q <= lo_q) begin
          mem_we    = 1'b1;
          mem_wdata = {cur_key, cur_delta[MassW-1:0]};
        end
      end
      ST_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = j_q[AW-1:0];
      end
      default: begin
        rd_addr = lo_q[AW-1:0];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DEL_RD && j_q >= count_q) begin
        count_q <= count_q - 1'b1;
      end else if (state_q == ST_INS_RD && j_q <= lo_q) begin
        count_q <= count_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_q     <= s_axis_tuser[0];
          two_q     <= s_axis_tuser[1];
          pos_a_q   <= s_axis_tdata[63:0];
          da_q      <= s_axis_tdata[96:64];
          pos_b_q   <= s_axis_tdata[160:97];
          db_q      <= s_axis_tdata[193:161];
          cur_b_q   <= 1'b0;
          dropped_q <= 1'b0;
          lo_q      <= '0;
          hi_q      <= count_q;
          app_a_q   <= '0;
          app_b_q   <= '0;
          lp_q      <= '0;
          lm_q      <= '0;
          rp_q      <= '0;
          rm_q      <= '0;
          status_q  <= STATUS_OK;
        end
      end
      ST_CMP: begin
        if (rd_key < cur_key) begin
          lo_q <= mid + 1'b1;
        end else begin
          hi_q <= mid;
        end
      end
      ST_PROBE: begin
        if (cmd_q == CMD_QUERY) begin
          if (!present) status_q <= STATUS_ABSENT;
        end else begin
          if (cur_b_q) begin
            app_b_q <= app_val;
          end else begin
            app_a_q <= app_val;
          end
          if (present) begin
            j_q <= lo_q + 1'b1;
          end else begin
            j_q <= count_q;
            if (delta_pos && full) dropped_q <= 1'b1;
          end
        end
      end
      ST_DEL_WR: j_q <= j_q + 1'b1;
      ST_INS_WR: j_q <= j_q - 1'b1;
      ST_NEXT: begin
        if (!cur_b_q && two_q) begin
          cur_b_q <= 1'b1;
          lo_q    <= '0;
          hi_q    <= count_q;
        end
      end
      ST_QL: begin
        lp_q <= rd_key;
        lm_q <= rd_mass;
      end
      ST_QR: begin
        rp_q <= rd_key;
        rm_q <= rd_mass;
      end
      default: begin
        lo_q <= lo_q;
      end
    endcase
    if (out_load) begin
      out_data_q <= {5'b0, CountW'(count_q), rm_q, rp_q, lm_q, lp_q, app_b_q, app_a_q};
      out_user_q <= dropped_q ? STATUS_FULL : status_q;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_search_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> (lo_q < hi_q && hi_q <= count_q))
    else $error("search bounds out of order");

  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INS_RD || state_q == ST_INS_WR) |-> (count_q < CW'(TABLE_DEPTH)))
    else $error("insert started on a full table");

  a_accept_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == ST_SRCH))
    else $error("accepted item did not start a search");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == STATUS_OK || m_axis_tuser == STATUS_FULL ||
                       m_axis_tuser == STATUS_ABSENT))
    else $error("invalid status code on output");

endmodule
